// ===== hw/rtl/lmss_pkg.sv =====
// Package with the constants and codes shared by the LED matrix scroll scanner.
`default_nettype none

package lmss_pkg;

  localparam int MAX_GLYPHS_DEFAULT = 16;
  localparam int GLYPH_BYTES        = 32;

  localparam logic [7:0] DIVIDER_RESET = 8'd180;
  localparam logic [4:0] SLOTS_RESET   = 5'd8;

  localparam int CFG_DATA_W  = 8;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_SCROLL_DIVIDER = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MESSAGE_SLOTS  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DISPLAY_MODE   = 2'd2;

  localparam logic [1:0] MODE_NORMAL      = 2'd0;
  localparam logic [1:0] MODE_MIRRORED    = 2'd1;
  localparam logic [1:0] MODE_ACTIVE_HIGH = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

endpackage : lmss_pkg

`default_nettype wire

// ===== hw/rtl/lmss_item_if.sv =====
// Input channel interface: glyph loads and row ticks.
`default_nettype none

interface lmss_item_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [8:0] glyph_address;
  logic [7:0] glyph_byte;

  modport source (output valid, output operation, output glyph_address, output glyph_byte,
                  input ready);
  modport sink (input valid, input operation, input glyph_address, input glyph_byte,
                output ready);
endinterface : lmss_item_if

`default_nettype wire

// ===== hw/rtl/lmss_result_if.sv =====
// Output channel interface: one scanned row per tick.
`default_nettype none

interface lmss_result_if;
  logic        valid;
  logic        ready;
  logic [3:0]  row_index;
  logic [15:0] row_select;
  logic [15:0] column_data;

  modport source (output valid, output row_index, output row_select, output column_data,
                  input ready);
  modport sink (input valid, input row_index, input row_select, input column_data,
                output ready);
endinterface : lmss_result_if

`default_nettype wire

// ===== hw/rtl/led_matrix_scroll_scanner.sv =====
// Scrolling LED matrix row scanner: glyph store, scroll counters and row output stage.
// A load writes the store at once; loads can follow every cycle while no tick is in flight.
// A tick reads three glyph bytes from the single-port store in phases 0..2; its row enters
// the output register in phase 3 once the output is free, and only then is a new item taken.
// Synchronous reset clears the counters, the sequencer and the output valid, and sets the
// configuration defaults; the glyph store is not cleared and is undefined until loaded.
`default_nettype none

module led_matrix_scroll_scanner
  import lmss_pkg::*;
#(
  parameter int MAX_GLYPHS = MAX_GLYPHS_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  lmss_item_if.sink                   item,
  lmss_result_if.source               result,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int STORE_SIZE = MAX_GLYPHS * GLYPH_BYTES;
  localparam int AW         = $clog2(STORE_SIZE);
  localparam int GW         = $clog2(MAX_GLYPHS);

  // Configuration registers.
  logic [7:0] scroll_divider;
  logic [4:0] message_slots;
  logic [1:0] display_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_divider <= DIVIDER_RESET;
      message_slots  <= SLOTS_RESET;
      display_mode   <= MODE_NORMAL;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SCROLL_DIVIDER: scroll_divider <= cfg_data;
        REG_MESSAGE_SLOTS:  message_slots  <= cfg_data[4:0];
        REG_DISPLAY_MODE:   display_mode   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic [1:0] mode;
  logic       swap;
  assign mode = (display_mode == MODE_MIRRORED || display_mode == MODE_ACTIVE_HIGH) ?
                display_mode : MODE_NORMAL;
  assign swap = (mode != MODE_NORMAL);

  // Scroll state and tick sequencer.
  logic [7:0]    tick_count;
  logic [3:0]    pixel_shift;
  logic [GW-1:0] glyph_position;
  logic [3:0]    scan_row;
  logic [3:0]    row;
  logic          busy;
  logic [1:0]    phase;
  logic [7:0]    byte0;
  logic [7:0]    byte1;

  logic out_free;
  logic finish;
  logic take;
  logic take_tick;
  logic take_load;

  assign out_free   = !result.valid || result.ready;
  assign finish     = busy && (phase == 2'd3) && out_free;
  assign item.ready = !busy || finish;
  assign take       = item.valid && item.ready;
  assign take_tick  = take && (item.operation == OP_TICK);
  assign take_load  = take && (item.operation == OP_LOAD);

  logic [7:0]    tick_next;
  logic          step;
  logic [3:0]    shift_next;
  logic [6:0]    slots_eff;
  logic          wrap;
  logic [GW-1:0] position_next;

  always_comb begin
    tick_next     = tick_count + 8'd1;
    step          = (tick_next == scroll_divider);
    shift_next    = pixel_shift;
    position_next = glyph_position;
    slots_eff     = (7'(message_slots) > 7'(MAX_GLYPHS)) ? 7'(MAX_GLYPHS) : 7'(message_slots);
    wrap          = (slots_eff < 7'd2) || ((7'(glyph_position) + 7'd1) >= (slots_eff - 7'd1));
    if (step) begin
      tick_next  = 8'd0;
      shift_next = pixel_shift + 4'd1;
      if (pixel_shift == 4'd15) begin
        position_next = wrap ? '0 : glyph_position + GW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count     <= 8'd0;
      pixel_shift    <= 4'd0;
      glyph_position <= '0;
      scan_row       <= 4'd0;
      busy           <= 1'b0;
      phase          <= 2'd0;
    end else begin
      if (take_tick) begin
        tick_count     <= tick_next;
        pixel_shift    <= shift_next;
        glyph_position <= position_next;
        scan_row       <= scan_row + 4'd1;
        busy           <= 1'b1;
        phase          <= 2'd0;
      end else if (finish) begin
        busy <= 1'b0;
      end else if (busy && phase != 2'd3) begin
        phase <= phase + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_tick) begin
      row <= scan_row;
    end
  end

  // Glyph store. Phases 0..2 read bytes k, k+1 and k+2 of the row's byte list; loads only
  // transfer while no read is in flight, so the port carries one access per cycle.
  logic [7:0]    store [STORE_SIZE];
  logic [7:0]    mem_q;
  logic          rd_en;
  logic [1:0]    list_idx;
  logic [GW-1:0] glyph_sel;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;

  assign rd_en     = busy && (phase != 2'd3);
  assign list_idx  = {1'b0, pixel_shift[3]} + phase;
  assign glyph_sel = list_idx[1] ? glyph_position + GW'(1) : glyph_position;
  assign rd_addr   = AW'({glyph_sel, row, list_idx[0] ^ swap});
  assign wr_addr   = AW'(item.glyph_address);
  assign wr_en     = take_load && (32'(item.glyph_address) < 32'(STORE_SIZE));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= item.glyph_byte;
    end
    if (rd_en) begin
      mem_q <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (busy && phase == 2'd1) begin
      byte0 <= mem_q;
    end
    if (busy && phase == 2'd2) begin
      byte1 <= mem_q;
    end
  end

  // Funnel shift and row driver word.
  logic [2:0]  s;
  logic [15:0] hi_pair;
  logic [15:0] lo_pair;
  logic [7:0]  first;
  logic [7:0]  second;
  logic [15:0] row_word;
  logic [7:0]  row_bit;

  assign s = pixel_shift[2:0];

  always_comb begin
    if (mode == MODE_MIRRORED) begin
      hi_pair = {byte1, byte0} >> s;
      lo_pair = {mem_q, byte1} >> s;
      first   = hi_pair[7:0];
      second  = lo_pair[7:0];
    end else begin
      hi_pair = {byte1, mem_q} << s;
      lo_pair = {byte0, byte1} << s;
      first   = hi_pair[15:8];
      second  = lo_pair[15:8];
    end
  end

  always_comb begin
    row_bit = 8'd0;
    if (mode == MODE_ACTIVE_HIGH) begin
      row_bit  = 8'h80 >> row[2:0];
      row_word = row[3] ? {row_bit, 8'h00} : {8'h00, row_bit};
    end else begin
      // Active-low rows are driven one row early: row zero and row eight take bit seven
      // of the opposite byte.
      if (row[2:0] == 3'd0) begin
        row_bit  = 8'h7f;
        row_word = row[3] ? {row_bit, 8'hff} : {8'hff, row_bit};
      end else begin
        row_bit  = ~(8'd1 << (row[2:0] - 3'd1));
        row_word = row[3] ? {8'hff, row_bit} : {row_bit, 8'hff};
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (finish) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result.row_index   <= row;
      result.row_select  <= row_word;
      result.column_data <= {first, second};
    end
  end

endmodule : led_matrix_scroll_scanner

`default_nettype wire

// ===== test/tb_led_matrix_scroll_scanner.sv =====
// Testbench for the LED matrix scroll scanner: row scan prediction and checking over several settings.
`timescale 1ns / 100ps

module tb_led_matrix_scroll_scanner;
  import lmss_pkg::*;

  localparam int GLYPH_SLOTS = MAX_GLYPHS_DEFAULT;
  localparam int STORE_BYTES = GLYPH_SLOTS * GLYPH_BYTES;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 500000;
  // Mode code the block treats like the normal mode.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [3:0]  row_index;
    logic [15:0] row_select;
    logic [15:0] column_data;
  } row_scan_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lmss_item_if item_bus ();
  lmss_result_if row_bus ();

  led_matrix_scroll_scanner dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_bus),
    .result    (row_bus),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the scanner state.
  logic [7:0] glyph_image [STORE_BYTES];
  logic [7:0] scan_ticks = 8'd0;
  logic [3:0] shift_pos = 4'd0;
  logic [3:0] lead_glyph = 4'd0;
  logic [3:0] next_row = 4'd0;
  logic [7:0] cfg_divider = DIVIDER_RESET;
  logic [4:0] cfg_slots = SLOTS_RESET;
  logic [1:0] cfg_mode = MODE_NORMAL;

  row_scan_t pending_rows [$];
  int failures = 0;
  int cycles = 0;
  int sender_idle_pct = 13;
  int receiver_idle_pct = 83;

  function automatic logic [7:0] glyph_read(int glyph, int offset);
    return glyph_image[(glyph * GLYPH_BYTES + offset) % STORE_BYTES];
  endfunction

  function automatic logic [7:0] shift_up(logic [7:0] v, int n);
    return (n >= 8) ? 8'h00 : 8'(v << n);
  endfunction

  function automatic logic [7:0] shift_down(logic [7:0] v, int n);
    return (n >= 8) ? 8'h00 : 8'(v >> n);
  endfunction

  function automatic logic [15:0] row_drive_word(logic [3:0] r, logic [1:0] mode);
    if (mode == MODE_ACTIVE_HIGH) begin
      if (r < 8) return 16'(8'h80 >> r);
      return {8'h80 >> (r - 8), 8'h00};
    end
    // Active-low rows, driven one row ahead of the scanned one.
    if (r == 0) return 16'hFF7F;
    if (r < 8) return {~(8'h01 << (r - 1)), 8'hFF};
    if (r == 8) return 16'h7FFF;
    return {8'hFF, ~(8'h01 << (r - 9))};
  endfunction

  function automatic void predict_scan(logic op, logic [8:0] addr, logic [7:0] data);
    logic [7:0] lane [4];
    logic [7:0] first;
    logic [7:0] second;
    logic [1:0] mode;
    int eff, cur, nxt, r, k, s;
    row_scan_t row;
    if (op == OP_LOAD) begin
      glyph_image[addr] = data;
      return;
    end
    scan_ticks = scan_ticks + 8'd1;
    if (scan_ticks == cfg_divider) begin
      scan_ticks = 8'd0;
      shift_pos = shift_pos + 4'd1;
      if (shift_pos == 4'd0) begin
        eff = (cfg_slots > GLYPH_SLOTS) ? GLYPH_SLOTS : int'(cfg_slots);
        if (eff < 2 || int'(lead_glyph) + 1 >= eff - 1) lead_glyph = 4'd0;
        else lead_glyph = lead_glyph + 4'd1;
      end
    end
    mode = (cfg_mode == MODE_MIRRORED || cfg_mode == MODE_ACTIVE_HIGH) ? cfg_mode : MODE_NORMAL;
    r = next_row;
    cur = lead_glyph;
    nxt = cur + 1;
    if (mode == MODE_NORMAL) begin
      lane[0] = glyph_read(cur, 2 * r);
      lane[1] = glyph_read(cur, 2 * r + 1);
      lane[2] = glyph_read(nxt, 2 * r);
      lane[3] = glyph_read(nxt, 2 * r + 1);
    end else begin
      lane[0] = glyph_read(cur, 2 * r + 1);
      lane[1] = glyph_read(cur, 2 * r);
      lane[2] = glyph_read(nxt, 2 * r + 1);
      lane[3] = glyph_read(nxt, 2 * r);
    end
    k = shift_pos[3];
    s = shift_pos[2:0];
    if (mode == MODE_MIRRORED) begin
      first = shift_down(lane[k], s) | shift_up(lane[1 + k], 8 - s);
      second = shift_down(lane[1 + k], s) | shift_up(lane[2 + k], 8 - s);
    end else begin
      first = shift_up(lane[1 + k], s) | shift_down(lane[2 + k], 8 - s);
      second = shift_up(lane[k], s) | shift_down(lane[1 + k], 8 - s);
    end
    row.row_index = next_row;
    row.row_select = row_drive_word(next_row, mode);
    row.column_data = {first, second};
    pending_rows.push_back(row);
    next_row = next_row + 4'd1;
  endfunction

  always @(posedge clk) begin
    if (!rst && item_bus.valid && item_bus.ready)
      predict_scan(item_bus.operation, item_bus.glyph_address, item_bus.glyph_byte);
  end

  always @(posedge clk) begin
    row_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  always @(posedge clk) begin : check_rows
    row_scan_t want;
    if (!rst && row_bus.valid && row_bus.ready) begin
      if (pending_rows.size() == 0) begin
        $error("row transfer with no scan pending: row_index %0d", row_bus.row_index);
        failures++;
      end else begin
        want = pending_rows.pop_front();
        if (row_bus.row_index !== want.row_index) begin
          $error("row_index: expected %0d, actual %0d", want.row_index, row_bus.row_index);
          failures++;
        end
        if (row_bus.row_select !== want.row_select) begin
          $error("row_select: expected %h, actual %h", want.row_select, row_bus.row_select);
          failures++;
        end
        if (row_bus.column_data !== want.column_data) begin
          $error("column_data: expected %h, actual %h", want.column_data, row_bus.column_data);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_item(input logic op, input logic [8:0] addr, input logic [7:0] data);
    while ($urandom_range(99) < sender_idle_pct) begin
      item_bus.valid <= 1'b0;
      @(posedge clk);
    end
    item_bus.valid <= 1'b1;
    item_bus.operation <= op;
    item_bus.glyph_address <= addr;
    item_bus.glyph_byte <= data;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
  endtask

  // Holds off the sender until every predicted row has been taken and the pipe is empty.
  // The first edge lets the prediction of the last transfer land in the queue.
  task automatic settle();
    item_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_registers(input logic [7:0] divider, input logic [4:0] slots,
                                 input logic [1:0] mode);
    settle();
    cfg_divider = divider;
    cfg_slots = slots;
    cfg_mode = mode;
    cfg_write <= 1'b1;
    cfg_index <= REG_SCROLL_DIVIDER;
    cfg_data <= divider;
    @(posedge clk);
    cfg_index <= REG_MESSAGE_SLOTS;
    cfg_data <= 8'(slots);
    @(posedge clk);
    cfg_index <= REG_DISPLAY_MODE;
    cfg_data <= 8'(mode);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic random_items(input int count, input int tick_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < tick_pct) send_item(OP_TICK, 9'($urandom), 8'($urandom));
      else send_item(OP_LOAD, 9'($urandom), 8'($urandom));
    end
  endtask

  // Every store byte is written before the first row scan, so no scan reads an empty entry.
  task automatic test_glyph_load();
    logic [7:0] data;
    for (int a = 0; a < STORE_BYTES; a++) begin
      case (a % 7)
        0: data = 8'hFF;
        1: data = 8'h00;
        default: data = 8'($urandom);
      endcase
      send_item(OP_LOAD, 9'(a), data);
    end
  endtask

  task automatic test_reset_registers();
    repeat (5) send_item(OP_TICK, 9'($urandom), 8'($urandom));
  endtask

  task automatic test_display_modes();
    logic [1:0] modes [4];
    modes = '{MODE_NORMAL, MODE_MIRRORED, MODE_ACTIVE_HIGH, MODE_SPARE};
    foreach (modes[i]) begin
      write_registers(8'd1, 5'd3, modes[i]);
      repeat (5) send_item(OP_TICK, 9'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_fast_scroll();
    repeat (4) begin
      write_registers(8'($urandom_range(1, 3)), 5'($urandom_range(2, 16)),
                      2'($urandom_range(0, 3)));
      random_items(40, 80);
    end
  endtask

  task automatic test_slot_extremes();
    int slot_cases [6];
    slot_cases = '{0, 1, 2, 16, 17, 31};
    foreach (slot_cases[i]) begin
      write_registers(8'd1, 5'(slot_cases[i]), 2'($urandom_range(0, 3)));
      random_items(30, 85);
    end
  endtask

  // A zero divider steps once per 256 ticks; a divider set below the running count
  // makes the count wrap through its top before the next step.
  task automatic test_divider_wrap();
    logic [7:0] lowered;
    write_registers(8'd0, 5'd16, MODE_NORMAL);
    random_items(300, 95);
    settle();
    lowered = (scan_ticks > 8'd1) ? scan_ticks / 2 : 8'd1;
    write_registers(lowered, 5'd16, MODE_MIRRORED);
    random_items(280, 95);
  endtask

  task automatic test_slow_divider();
    write_registers(8'd255, 5'd16, MODE_ACTIVE_HIGH);
    random_items(100, 90);
  endtask

  task automatic test_mixed_settings();
    repeat (5) begin
      write_registers(8'($urandom_range(1, 4)), 5'($urandom_range(2, 16)),
                      2'($urandom_range(0, 3)));
      random_items(20, 75);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_SCROLL_DIVIDER;
    cfg_data = '0;
    item_bus.valid = 1'b0;
    item_bus.operation = OP_LOAD;
    item_bus.glyph_address = '0;
    item_bus.glyph_byte = '0;
    row_bus.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_glyph_load();
    test_reset_registers();
    test_display_modes();
    test_fast_scroll();

    sender_idle_pct = 83;
    receiver_idle_pct = 13;
    test_slot_extremes();

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    test_divider_wrap();
    test_slow_divider();
    test_mixed_settings();

    settle();
    repeat (16) @(posedge clk);
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
